[hw/rtl/gdrc_pkg.sv]
// ----------------------------------------------------------------------------
// gdrc_pkg
// Shared constants, codes and controller/datapath interface types for the
// grid DDA column raycaster.
// ----------------------------------------------------------------------------
package gdrc_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam int MAP_DIM       = 64;
  localparam int MAX_STEPS     = 128;

  localparam int HALF_H  = SCREEN_HEIGHT / 2;
  localparam int MAP_AW  = $clog2(MAP_DIM);
  localparam int CNT_W   = $clog2(MAX_STEPS + 1);
  // signed map coordinate: start cell plus up to MAX_STEPS steps either way
  localparam int CRD_W   = $clog2(MAP_DIM + MAX_STEPS) + 1;
  // side distance accumulators: first distance below 2^33 plus the steps
  localparam int SD_W    = 33 + CNT_W;
  localparam int DIV_QW  = 32;
  localparam int DIV_VW  = SD_W;
  localparam int CAM_W   = 17;
  localparam int RAY_W   = 19;
  // camera offset: column * 2^15 / SCREEN_WIDTH as (column * CAM_MUL) >> 10
  localparam int CAM_MUL = (2 ** 25 + SCREEN_WIDTH - 1) / SCREEN_WIDTH;

  localparam logic [7:0] SHADE_X = 8'd220;
  localparam logic [7:0] SHADE_Y = 8'd150;

  // configuration register indexes
  localparam logic [2:0] REG_POS_X   = 3'd0;
  localparam logic [2:0] REG_POS_Y   = 3'd1;
  localparam logic [2:0] REG_DIR_X   = 3'd2;
  localparam logic [2:0] REG_DIR_Y   = 3'd3;
  localparam logic [2:0] REG_PLANE_X = 3'd4;
  localparam logic [2:0] REG_PLANE_Y = 3'd5;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CAM, ST_RAYX, ST_RAYY, ST_RAYE, ST_RCPX, ST_RCPY,
    ST_SIDEX, ST_SIDEY, ST_STEP, ST_CHECK, ST_LINE, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    DSEL_CAM, DSEL_RX, DSEL_RY, DSEL_LINE
  } dsel_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_WRITE, OP_CAST, OP_CAM, OP_RAYX, OP_RAYY, OP_RAYE,
    OP_DLX, OP_DLY, OP_SIDEX, OP_SIDEY, OP_STEP, OP_HIT, OP_MISS, OP_OUT
  } op_t;

  typedef struct packed {
    op_t   op;
    logic  div_start;
    dsel_t div_sel;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic hit_now;
    logic steps_max;
    logic out_free;
  } status_t;

endpackage

[hw/rtl/gdrc_div.sv]
// ----------------------------------------------------------------------------
// gdrc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gdrc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [gdrc_pkg::DIV_QW-1:0]    dividend,
  input  logic [gdrc_pkg::DIV_VW-1:0]    divisor,
  output logic                           busy,
  output logic [gdrc_pkg::DIV_QW-1:0]    quotient
);

  logic [gdrc_pkg::DIV_VW-1:0]         rem;
  logic [gdrc_pkg::DIV_VW-1:0]         dvs;
  logic [$clog2(gdrc_pkg::DIV_QW)-1:0] cnt;
  logic [gdrc_pkg::DIV_VW:0]           trial;
  logic                                fits;

  // shift in the next dividend bit and test against the divisor
  assign trial = {rem, quotient[gdrc_pkg::DIV_QW-1]};
  assign fits  = trial >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == '1) busy <= 1'b0;
    end
  end

  // iterate
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= gdrc_pkg::DIV_VW'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[gdrc_pkg::DIV_VW-1:0];
      end
      quotient <= {quotient[gdrc_pkg::DIV_QW-2:0], fits};
    end
  end

endmodule

[hw/rtl/gdrc_dp.sv]
// ----------------------------------------------------------------------------
// gdrc_dp
// Datapath: configuration registers, map memory, ray setup, DDA walk
// registers, shared divider and the output word register.
// ----------------------------------------------------------------------------
module gdrc_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  gdrc_pkg::cmd_t        cmd,
  output gdrc_pkg::status_t     status,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic [9:0]            column,
  input  logic [5:0]            cell_x,
  input  logic [5:0]            cell_y,
  input  logic [7:0]            cell_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [9:0]            out_column,
  output logic [8:0]            top_row,
  output logic [8:0]            bottom_row,
  output logic                  side,
  output logic [7:0]            red_shade,
  output logic [7:0]            hit_cell,
  output logic                  hit_found
);

  localparam int AW = 2 * gdrc_pkg::MAP_AW;

  logic [15:0] pos_x, pos_y, dir_x, dir_y, plane_x, plane_y;

  logic [7:0] mem [gdrc_pkg::MAP_DIM * gdrc_pkg::MAP_DIM];
  logic [7:0] rd_data;
  logic [AW-1:0] rd_addr;

  logic [9:0]                        col;
  logic [25:0]                       cam_scaled;
  logic signed [gdrc_pkg::CAM_W-1:0] cam;
  logic signed [32:0]                prod;
  logic signed [gdrc_pkg::RAY_W-1:0] rx, ry;
  logic [gdrc_pkg::RAY_W-1:0]        ax, ay;
  logic [31:0]                       dlx, dly;
  logic [gdrc_pkg::SD_W-1:0]         sdx, sdy;
  logic signed [gdrc_pkg::CRD_W-1:0] mx, my, mx_next, my_next;
  logic [gdrc_pkg::CNT_W-1:0]        n;
  logic                              side_r, oob, hit, perp_zero, step_x;
  logic [7:0]                        code;
  logic [10:0]                       fx, fy;
  logic [42:0]                       side_prod;
  logic [gdrc_pkg::SD_W-1:0]         perp;

  logic                              div_busy;
  logic [gdrc_pkg::DIV_QW-1:0]       q, div_dividend;
  logic [gdrc_pkg::DIV_VW-1:0]       div_divisor;
  logic [31:0]                       h;
  logic [30:0]                       hh;
  logic [8:0]                        top_next, bot_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= 16'd1536;
      pos_y   <= 16'd1536;
      dir_x   <= 16'hC000;
      dir_y   <= 16'd0;
      plane_x <= 16'd0;
      plane_y <= 16'd10813;
    end else if (cfg_we) begin
      case (cfg_index)
        gdrc_pkg::REG_POS_X:   pos_x   <= cfg_data;
        gdrc_pkg::REG_POS_Y:   pos_y   <= cfg_data;
        gdrc_pkg::REG_DIR_X:   dir_x   <= cfg_data;
        gdrc_pkg::REG_DIR_Y:   dir_y   <= cfg_data;
        gdrc_pkg::REG_PLANE_X: plane_x <= cfg_data;
        gdrc_pkg::REG_PLANE_Y: plane_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // map memory: write port and registered read port
  always_ff @(posedge clk) begin
    if (cmd.op == gdrc_pkg::OP_WRITE) begin
      mem[{cell_y[gdrc_pkg::MAP_AW-1:0], cell_x[gdrc_pkg::MAP_AW-1:0]}] <= cell_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == gdrc_pkg::OP_STEP) rd_data <= mem[rd_addr];
  end

  // camera offset by reciprocal multiply of the latched column
  assign cam_scaled = 26'(col * 16'(gdrc_pkg::CAM_MUL));

  // magnitudes and first-side fractions
  assign ax = rx[gdrc_pkg::RAY_W-1] ? gdrc_pkg::RAY_W'(-rx) : rx;
  assign ay = ry[gdrc_pkg::RAY_W-1] ? gdrc_pkg::RAY_W'(-ry) : ry;
  assign fx = rx[gdrc_pkg::RAY_W-1] ? {1'b0, pos_x[9:0]} : 11'd1024 - {1'b0, pos_x[9:0]};
  assign fy = ry[gdrc_pkg::RAY_W-1] ? {1'b0, pos_y[9:0]} : 11'd1024 - {1'b0, pos_y[9:0]};
  assign side_prod = (cmd.op == gdrc_pkg::OP_SIDEX) ? fx * dlx : fy * dly;

  // one DDA step
  assign step_x  = sdx < sdy;
  assign mx_next = step_x ? (rx[gdrc_pkg::RAY_W-1] ? mx - 1'b1 : mx + 1'b1) : mx;
  assign my_next = step_x ? my : (ry[gdrc_pkg::RAY_W-1] ? my - 1'b1 : my + 1'b1);
  assign rd_addr = {my_next[gdrc_pkg::MAP_AW-1:0], mx_next[gdrc_pkg::MAP_AW-1:0]};

  assign perp = side_r ? sdy - gdrc_pkg::SD_W'(dly) : sdx - gdrc_pkg::SD_W'(dlx);

  // divider operand select
  always_comb begin
    case (cmd.div_sel)
      gdrc_pkg::DSEL_RX: begin
        div_dividend = 32'h4000_0000;
        div_divisor  = gdrc_pkg::DIV_VW'(ax);
      end
      gdrc_pkg::DSEL_RY: begin
        div_dividend = 32'h4000_0000;
        div_divisor  = gdrc_pkg::DIV_VW'(ay);
      end
      default: begin
        div_dividend = 32'(gdrc_pkg::SCREEN_HEIGHT * 65536);
        div_divisor  = perp;
      end
    endcase
  end

  gdrc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (q)
  );

  // ray setup and walk registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      gdrc_pkg::OP_CAST: col <= column;
      gdrc_pkg::OP_CAM:  cam <= $signed({1'b0, cam_scaled[25:10]}) - 17'sd16384;
      gdrc_pkg::OP_RAYX: prod <= $signed(plane_x) * cam;
      gdrc_pkg::OP_RAYY: begin
        rx   <= gdrc_pkg::RAY_W'($signed(dir_x)) + gdrc_pkg::RAY_W'(prod >>> 14);
        prod <= $signed(plane_y) * cam;
      end
      gdrc_pkg::OP_RAYE: ry <= gdrc_pkg::RAY_W'($signed(dir_y)) + gdrc_pkg::RAY_W'(prod >>> 14);
      gdrc_pkg::OP_DLX:  dlx <= (ax == '0) ? 32'hFFFF_FFFF : q;
      gdrc_pkg::OP_DLY:  dly <= (ay == '0) ? 32'hFFFF_FFFF : q;
      gdrc_pkg::OP_SIDEX: begin
        sdx <= gdrc_pkg::SD_W'(side_prod[42:10]);
        mx  <= gdrc_pkg::CRD_W'({1'b0, pos_x[15:10]});
        n   <= '0;
      end
      gdrc_pkg::OP_SIDEY: begin
        sdy <= gdrc_pkg::SD_W'(side_prod[42:10]);
        my  <= gdrc_pkg::CRD_W'({1'b0, pos_y[15:10]});
      end
      gdrc_pkg::OP_STEP: begin
        if (step_x) sdx <= sdx + gdrc_pkg::SD_W'(dlx);
        else        sdy <= sdy + gdrc_pkg::SD_W'(dly);
        mx     <= mx_next;
        my     <= my_next;
        side_r <= !step_x;
        n      <= n + 1'b1;
        oob    <= mx_next < 0 || my_next < 0 ||
                  mx_next > gdrc_pkg::CRD_W'(gdrc_pkg::MAP_DIM - 1) ||
                  my_next > gdrc_pkg::CRD_W'(gdrc_pkg::MAP_DIM - 1);
      end
      gdrc_pkg::OP_HIT: begin
        hit       <= 1'b1;
        code      <= oob ? 8'd0 : rd_data;
        perp_zero <= perp == '0;
      end
      gdrc_pkg::OP_MISS: hit <= 1'b0;
      default: ;
    endcase
  end

  // slice rows from line height
  assign h  = perp_zero ? 32'(2 * gdrc_pkg::SCREEN_HEIGHT) : q;
  assign hh = h[31:1];
  assign top_next = (hh >= 31'(gdrc_pkg::HALF_H)) ? 9'd0 : 9'(gdrc_pkg::HALF_H - 32'(hh));
  assign bot_next = (hh >= 31'(gdrc_pkg::SCREEN_HEIGHT - gdrc_pkg::HALF_H)) ?
                    9'(gdrc_pkg::SCREEN_HEIGHT - 1) : 9'(gdrc_pkg::HALF_H + 32'(hh));

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == gdrc_pkg::OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == gdrc_pkg::OP_OUT) begin
      out_column <= col;
      hit_found  <= hit;
      top_row    <= hit ? top_next : 9'd0;
      bottom_row <= hit ? bot_next : 9'd0;
      side       <= hit & side_r;
      red_shade  <= hit ? (side_r ? gdrc_pkg::SHADE_Y : gdrc_pkg::SHADE_X) : 8'd0;
      hit_cell   <= hit ? code : 8'd0;
    end
  end

  assign status.div_busy  = div_busy;
  assign status.hit_now   = oob || rd_data != 8'd0;
  assign status.steps_max = n == gdrc_pkg::CNT_W'(gdrc_pkg::MAX_STEPS);
  assign status.out_free  = !out_valid || out_ready;

endmodule

[hw/rtl/gdrc_ctrl.sv]
// ----------------------------------------------------------------------------
// gdrc_ctrl
// Controller: takes map writes and casts, sequences ray setup, the DDA walk, the line division and the output word.
// ----------------------------------------------------------------------------
module gdrc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                func,
  output logic                in_ready,
  input  gdrc_pkg::status_t   status,
  output gdrc_pkg::cmd_t      cmd
);

  gdrc_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= gdrc_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd.op        = gdrc_pkg::OP_NONE;
    cmd.div_start = 1'b0;
    cmd.div_sel   = gdrc_pkg::DSEL_CAM;
    in_ready      = 1'b0;
    case (state)
      gdrc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (func == gdrc_pkg::FUNC_CAST) begin
            cmd.op     = gdrc_pkg::OP_CAST;
            state_next = gdrc_pkg::ST_CAM;
          end else begin
            cmd.op = gdrc_pkg::OP_WRITE;
          end
        end
      end
      gdrc_pkg::ST_CAM: begin
        cmd.op     = gdrc_pkg::OP_CAM;
        state_next = gdrc_pkg::ST_RAYX;
      end
      gdrc_pkg::ST_RAYX: begin
        cmd.op     = gdrc_pkg::OP_RAYX;
        state_next = gdrc_pkg::ST_RAYY;
      end
      gdrc_pkg::ST_RAYY: begin
        cmd.op     = gdrc_pkg::OP_RAYY;
        state_next = gdrc_pkg::ST_RAYE;
      end
      gdrc_pkg::ST_RAYE: begin
        cmd.op        = gdrc_pkg::OP_RAYE;
        cmd.div_start = 1'b1;
        cmd.div_sel   = gdrc_pkg::DSEL_RX;
        state_next    = gdrc_pkg::ST_RCPX;
      end
      gdrc_pkg::ST_RCPX: begin
        if (!status.div_busy) begin
          cmd.op        = gdrc_pkg::OP_DLX;
          cmd.div_start = 1'b1;
          cmd.div_sel   = gdrc_pkg::DSEL_RY;
          state_next    = gdrc_pkg::ST_RCPY;
        end
      end
      gdrc_pkg::ST_RCPY: begin
        cmd.div_sel = gdrc_pkg::DSEL_RY;
        if (!status.div_busy) begin
          cmd.op     = gdrc_pkg::OP_DLY;
          state_next = gdrc_pkg::ST_SIDEX;
        end
      end
      gdrc_pkg::ST_SIDEX: begin
        cmd.op     = gdrc_pkg::OP_SIDEX;
        state_next = gdrc_pkg::ST_SIDEY;
      end
      gdrc_pkg::ST_SIDEY: begin
        cmd.op     = gdrc_pkg::OP_SIDEY;
        state_next = gdrc_pkg::ST_STEP;
      end
      gdrc_pkg::ST_STEP: begin
        cmd.op     = gdrc_pkg::OP_STEP;
        state_next = gdrc_pkg::ST_CHECK;
      end
      gdrc_pkg::ST_CHECK: begin
        cmd.div_sel = gdrc_pkg::DSEL_LINE;
        if (status.hit_now) begin
          cmd.op        = gdrc_pkg::OP_HIT;
          cmd.div_start = 1'b1;
          state_next    = gdrc_pkg::ST_LINE;
        end else if (status.steps_max) begin
          cmd.op     = gdrc_pkg::OP_MISS;
          state_next = gdrc_pkg::ST_DONE;
        end else begin
          state_next = gdrc_pkg::ST_STEP;
        end
      end
      gdrc_pkg::ST_LINE: begin
        cmd.div_sel = gdrc_pkg::DSEL_LINE;
        if (!status.div_busy) state_next = gdrc_pkg::ST_DONE;
      end
      gdrc_pkg::ST_DONE: begin
        cmd.div_sel = gdrc_pkg::DSEL_LINE;
        if (status.out_free) begin
          cmd.op     = gdrc_pkg::OP_OUT;
          state_next = gdrc_pkg::ST_IDLE;
        end
      end
      default: state_next = gdrc_pkg::ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/grid_dda_raycast_column.sv]
// ----------------------------------------------------------------------------
// grid_dda_raycast_column
// Column raycaster over a 64x64 cell map: DDA grid walk, perpendicular
// distance and clamped wall slice rows for one screen column per cast.
//
//   channel   handshake                  word
//   in        in_valid / in_ready        func, column, cell_x, cell_y, cell_value
//   out       out_valid / out_ready      out_column .. hit_found
//   cfg       cfg_we (no wait)           cfg_index, cfg_data
//
// A write word is taken and stored in the idle state. A cast walks up to 128
// grid steps. It waits on the shared divider for the two reciprocals and,
// when a wall is hit, for the line height; the camera offset comes from a
// reciprocal multiply of the column, and each step passes ST_STEP and
// ST_CHECK for the registered map read. Reset clears control and loads the
// register defaults; map contents are undefined until written. A stalled
// result waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module grid_dda_raycast_column (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [9:0]  column,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic [7:0]  cell_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_column,
  output logic [8:0]  top_row,
  output logic [8:0]  bottom_row,
  output logic        side,
  output logic [7:0]  red_shade,
  output logic [7:0]  hit_cell,
  output logic        hit_found
);

  gdrc_pkg::cmd_t    cmd;
  gdrc_pkg::status_t status;

  gdrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  gdrc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .column     (column),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_value (cell_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_column (out_column),
    .top_row    (top_row),
    .bottom_row (bottom_row),
    .side       (side),
    .red_shade  (red_shade),
    .hit_cell   (hit_cell),
    .hit_found  (hit_found)
  );

endmodule
